/* rtl/srcs_pkg.sv */
// Package for the spectrum residual and chi-square statistics unit.
// Holds field widths, configuration register indexes and the queue entry type.
// No dependencies.
package srcs_pkg;

  localparam int unsigned CountBits   = 24;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned CalcBits    = 32;
  localparam int unsigned ResBits     = CountBits + FracBits + 1;
  localparam int unsigned MagBits     = CountBits + FracBits;
  localparam int unsigned MaxChannels = 4096;
  localparam int unsigned IdxBits     = 12;
  localparam int unsigned ChanBits    = IdxBits + 1;
  localparam int unsigned CompBits    = 6;
  localparam int unsigned ProdBits    = 2 * MagBits;
  localparam int unsigned DivisorBits = CountBits + 1;
  localparam int unsigned CntBits     = 6;
  localparam int unsigned TotBits     = 36;
  localparam int unsigned CalcSumBits = 44;
  localparam int unsigned ChiBits     = 64;
  localparam int unsigned RedBits     = 48;
  localparam int unsigned CfgAddrBits = 2;
  localparam int unsigned CfgDataBits = 12;

  typedef logic [CfgAddrBits-1:0] cfg_addr_t;

  localparam cfg_addr_t CfgRegionStart  = 2'd0;
  localparam cfg_addr_t CfgRegionEnd    = 2'd1;
  localparam cfg_addr_t CfgFittedComps  = 2'd2;

  typedef struct packed {
    logic [CountBits-1:0] m;
    logic [CalcBits-1:0]  c;
    logic [MagBits-1:0]   mag;
    logic [ResBits-1:0]   res;
    logic                 last;
    logic                 in_region;
    logic [ChanBits-1:0]  channels;
  } chan_t;

endpackage

/* rtl/srcs_front.sv */
// Front end: accepts channels, forms residual and region flag, tracks the index.
// Feeds a two-entry queue read by srcs_back. Depends on srcs_pkg.
module srcs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [srcs_pkg::CountBits-1:0]  measured_count_i,
  input  logic [srcs_pkg::CalcBits-1:0]   calculated_count_i,
  input  logic                            last_channel_i,
  input  logic [srcs_pkg::IdxBits-1:0]    region_start_i,
  input  logic [srcs_pkg::IdxBits-1:0]    region_end_i,
  input  logic                            q_pop_i,
  output logic                            q_valid_o,
  output srcs_pkg::chan_t                 q_head_o
);

  srcs_pkg::chan_t                 ent_q [2];
  logic                            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]                      cnt_q, cnt_d;
  logic [srcs_pkg::IdxBits-1:0]    idx_q, idx_d;
  logic                            acc;
  logic                            last;
  logic [srcs_pkg::MagBits-1:0]    mq;
  srcs_pkg::chan_t                 ent;

  assign full      = (cnt_q == 2'd2);
  assign acc       = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o  = ent_q[rd_q];

  always_comb begin
    last = last_channel_i ||
           (idx_q == srcs_pkg::IdxBits'(srcs_pkg::MaxChannels - 1));
    mq = {measured_count_i, {srcs_pkg::FracBits{1'b0}}};
    ent.m = measured_count_i;
    ent.c = calculated_count_i;
    if (mq >= calculated_count_i) begin
      ent.mag = mq - calculated_count_i;
      ent.res = {1'b0, ent.mag};
    end else begin
      ent.mag = calculated_count_i - mq;
      ent.res = -{1'b0, ent.mag};
    end
    ent.last      = last;
    ent.in_region = !last && (idx_q >= region_start_i) && (idx_q < region_end_i);
    ent.channels  = {1'b0, idx_q} + srcs_pkg::ChanBits'(1);
    idx_d = idx_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (acc) begin
      idx_d = last ? '0 : idx_q + srcs_pkg::IdxBits'(1);
      wr_d  = ~wr_q;
    end
    if (q_pop_i) begin
      rd_d = ~rd_q;
    end
    cnt_d = cnt_q + 2'(acc) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q[wr_q] <= ent;
    end
  end

endmodule

/* rtl/srcs_back.sv */
// Back end: squares the residual, divides by measured+2 one bit a cycle,
// accumulates the sums and forms the summary on the last channel. Depends on srcs_pkg.
module srcs_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  srcs_pkg::chan_t                     q_head_i,
  output logic                                q_pop_o,
  input  logic [srcs_pkg::CompBits-1:0]       fitted_components_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [srcs_pkg::ResBits-1:0] residual_o,
  output logic                                stats_valid_o,
  output logic [srcs_pkg::TotBits-1:0]        total_counts_o,
  output logic [srcs_pkg::TotBits-1:0]        region_counts_o,
  output logic [srcs_pkg::RedBits-1:0]        reduced_chisq_o,
  output logic                                dof_error_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_ACC, S_OUT
  } state_e;

  localparam int unsigned RemBits = srcs_pkg::DivisorBits + 1;

  state_e                             state_q;
  srcs_pkg::chan_t                    ent_q;
  logic [srcs_pkg::ProdBits-1:0]      dq_q, dq_n;
  logic [RemBits-1:0]                 rem_q, rem_sh, rem_n;
  logic [srcs_pkg::DivisorBits-1:0]   dvs_q;
  logic [srcs_pkg::CntBits-1:0]       cnt_q;
  logic                               final_q, ge;
  logic [srcs_pkg::TotBits-1:0]       mt_q, mr_q;
  logic [srcs_pkg::CalcSumBits-1:0]   ct_q, cr_q;
  logic [srcs_pkg::ChiBits-1:0]       chi_q;
  logic [srcs_pkg::RedBits-1:0]       red_q;
  logic                               derr_q;
  logic                               out_valid_q;
  logic [srcs_pkg::TotBits:0]         mt_s, mr_s;
  logic [srcs_pkg::CalcSumBits:0]     ct_s, cr_s;
  logic [srcs_pkg::ChiBits:0]         chi_s;
  logic [srcs_pkg::ChiBits-1:0]       chi_n, term;
  logic [srcs_pkg::ChanBits-1:0]      dof;
  logic                               wr_out;
  logic [srcs_pkg::TotBits-1:0]       tot, regc;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign wr_out  = (state_q == S_OUT) && (!out_valid_q || pop);
  assign empty   = !out_valid_q;

  always_comb begin
    rem_sh = {rem_q[RemBits-2:0], dq_q[srcs_pkg::ProdBits-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_n  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
    dq_n   = {dq_q[srcs_pkg::ProdBits-2:0], ge};
    term   = dq_q >> srcs_pkg::FracBits;
    mt_s   = {1'b0, mt_q} + (srcs_pkg::TotBits+1)'(ent_q.m);
    mr_s   = {1'b0, mr_q} + (srcs_pkg::TotBits+1)'(ent_q.m);
    ct_s   = {1'b0, ct_q} + (srcs_pkg::CalcSumBits+1)'(ent_q.c);
    cr_s   = {1'b0, cr_q} + (srcs_pkg::CalcSumBits+1)'(ent_q.c);
    chi_s  = {1'b0, chi_q} + {1'b0, term};
    chi_n  = chi_s[srcs_pkg::ChiBits] ? '1 : chi_s[srcs_pkg::ChiBits-1:0];
    dof    = ent_q.channels - srcs_pkg::ChanBits'(fitted_components_i);
    tot    = (mt_q == '0) ? srcs_pkg::TotBits'(ct_q >> srcs_pkg::FracBits) : mt_q;
    regc   = (mr_q == '0) ? srcs_pkg::TotBits'(cr_q >> srcs_pkg::FracBits) : mr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      final_q     <= 1'b0;
      mt_q        <= '0;
      mr_q        <= '0;
      ct_q        <= '0;
      cr_q        <= '0;
      chi_q       <= '0;
      red_q       <= '0;
      derr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && out_valid_q && !wr_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q   <= '0;
          final_q <= 1'b0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + srcs_pkg::CntBits'(1);
          if (cnt_q == '1) begin
            if (final_q) begin
              red_q   <= (dq_n[srcs_pkg::ProdBits-1:srcs_pkg::RedBits] != '0) ? '1
                         : dq_n[srcs_pkg::RedBits-1:0];
              derr_q  <= 1'b0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_ACC;
            end
          end
        end
        S_ACC: begin
          chi_q <= chi_n;
          mt_q  <= mt_s[srcs_pkg::TotBits] ? '1 : mt_s[srcs_pkg::TotBits-1:0];
          ct_q  <= ct_s[srcs_pkg::CalcSumBits] ? '1 : ct_s[srcs_pkg::CalcSumBits-1:0];
          if (ent_q.in_region) begin
            mr_q <= mr_s[srcs_pkg::TotBits] ? '1 : mr_s[srcs_pkg::TotBits-1:0];
            cr_q <= cr_s[srcs_pkg::CalcSumBits] ? '1 : cr_s[srcs_pkg::CalcSumBits-1:0];
          end
          if (!ent_q.last) begin
            red_q   <= '0;
            derr_q  <= 1'b0;
            state_q <= S_OUT;
          end else if (ent_q.channels <= srcs_pkg::ChanBits'(fitted_components_i)) begin
            red_q   <= '1;
            derr_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            cnt_q   <= '0;
            final_q <= 1'b1;
            state_q <= S_DIV;
          end
        end
        S_OUT: begin
          if (wr_out) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (ent_q.last) begin
              mt_q  <= '0;
              mr_q  <= '0;
              ct_q  <= '0;
              cr_q  <= '0;
              chi_q <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_head_i;
    end
    unique case (state_q)
      S_MUL: begin
        dq_q  <= ent_q.mag * ent_q.mag;
        rem_q <= '0;
        dvs_q <= srcs_pkg::DivisorBits'(ent_q.m) + srcs_pkg::DivisorBits'(2);
      end
      S_DIV: begin
        dq_q  <= dq_n;
        rem_q <= rem_n;
      end
      S_ACC: begin
        dq_q  <= chi_n;
        rem_q <= '0;
        dvs_q <= srcs_pkg::DivisorBits'(dof);
      end
      default: ;
    endcase
    if (wr_out) begin
      residual_o      <= ent_q.res;
      stats_valid_o   <= ent_q.last;
      total_counts_o  <= ent_q.last ? tot : '0;
      region_counts_o <= ent_q.last ? regc : '0;
      reduced_chisq_o <= ent_q.last ? red_q : '0;
      dof_error_o     <= ent_q.last ? derr_q : 1'b0;
    end
  end

  a_derr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && dof_error_o) |-> (stats_valid_o && reduced_chisq_o == '1))
    else $error("dof error without saturated summary");

  a_plain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !stats_valid_o) |->
      (total_counts_o == '0 && region_counts_o == '0 &&
       reduced_chisq_o == '0 && !dof_error_o))
    else $error("summary fields set on a non-final channel");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '1) |=> (state_q == S_ACC || state_q == S_OUT))
    else $error("divider finished into the wrong state");

endmodule

/* rtl/spectrum_residual_chisq_stats_unit.sv */
// Spectrum residual and reduced chi-square statistics unit, top level.
// In the back end a channel runs multiply, 64-step divide, accumulate and output;
// a last channel with a valid degree count adds a second 64-step divide for the
// reduced chi-square, on the shared one-bit-per-cycle divider. A two-entry queue
// lets input run ahead. Reset clears all sums, the channel index and queues, and
// loads the configuration reset values. Depends on srcs_pkg, srcs_front, srcs_back.
module spectrum_residual_chisq_stats_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srcs_pkg::CfgAddrBits-1:0]     cfg_idx_i,
  input  logic [srcs_pkg::CfgDataBits-1:0]     cfg_wdata_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic [srcs_pkg::CountBits-1:0]       measured_count_i,
  input  logic [srcs_pkg::CalcBits-1:0]        calculated_count_i,
  input  logic                                 last_channel_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [srcs_pkg::ResBits-1:0]  residual_o,
  output logic                                 stats_valid_o,
  output logic [srcs_pkg::TotBits-1:0]         total_counts_o,
  output logic [srcs_pkg::TotBits-1:0]         region_counts_o,
  output logic [srcs_pkg::RedBits-1:0]         reduced_chisq_o,
  output logic                                 dof_error_o
);

  logic [srcs_pkg::IdxBits-1:0]  start_q, end_q;
  logic [srcs_pkg::CompBits-1:0] comps_q;
  logic                          q_pop, q_valid;
  srcs_pkg::chan_t               q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '1;
      comps_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srcs_pkg::CfgRegionStart: start_q <= cfg_wdata_i[srcs_pkg::IdxBits-1:0];
        srcs_pkg::CfgRegionEnd:   end_q   <= cfg_wdata_i[srcs_pkg::IdxBits-1:0];
        srcs_pkg::CfgFittedComps: comps_q <= cfg_wdata_i[srcs_pkg::CompBits-1:0];
        default: ;
      endcase
    end
  end

  srcs_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .measured_count_i   (measured_count_i),
    .calculated_count_i (calculated_count_i),
    .last_channel_i     (last_channel_i),
    .region_start_i     (start_q),
    .region_end_i       (end_q),
    .q_pop_i            (q_pop),
    .q_valid_o          (q_valid),
    .q_head_o           (q_head)
  );

  srcs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_head_i            (q_head),
    .q_pop_o             (q_pop),
    .fitted_components_i (comps_q),
    .empty               (empty),
    .pop                 (pop),
    .residual_o          (residual_o),
    .stats_valid_o       (stats_valid_o),
    .total_counts_o      (total_counts_o),
    .region_counts_o     (region_counts_o),
    .reduced_chisq_o     (reduced_chisq_o),
    .dof_error_o         (dof_error_o)
  );

endmodule

/* tb/tb_spectrum_residual_chisq_stats_unit.sv */
// Self-checking testbench for the spectrum residual and chi-square statistics unit.
// A directed table of channels and then random spectra are checked against a
// behavioral predictor of the channel statistics. Depends on srcs_pkg and the RTL.
module tb_spectrum_residual_chisq_stats_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import srcs_pkg::*;

  typedef struct packed {
    logic [ResBits-1:0] residual;
    logic               stats_valid;
    logic [TotBits-1:0] total_counts;
    logic [TotBits-1:0] region_counts;
    logic [RedBits-1:0] reduced_chisq;
    logic               dof_error;
  } chan_stats_t;

  typedef struct {
    logic [CountBits-1:0] meas;
    logic [CalcBits-1:0]  calc;
    logic                 last;
    logic                 has_expected;
    chan_stats_t          expected;
  } chan_row_t;

  localparam int unsigned NumRandom = 1230;
  localparam longint unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 300;
  localparam logic [63:0] Sum36Max = 64'h0000_000F_FFFF_FFFF;
  localparam logic [63:0] Sum44Max = 64'h0000_0FFF_FFFF_FFFF;
  localparam logic [63:0] Chi48Max = 64'h0000_FFFF_FFFF_FFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgAddrBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [CountBits-1:0]   measured_count_i = '0;
  logic [CalcBits-1:0]    calculated_count_i = '0;
  logic                   last_channel_i = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic signed [ResBits-1:0] residual_o;
  logic                   stats_valid_o;
  logic [TotBits-1:0]     total_counts_o;
  logic [TotBits-1:0]     region_counts_o;
  logic [RedBits-1:0]     reduced_chisq_o;
  logic                   dof_error_o;

  spectrum_residual_chisq_stats_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .push, .full,
    .measured_count_i, .calculated_count_i, .last_channel_i, .empty, .pop,
    .residual_o, .stats_valid_o, .total_counts_o, .region_counts_o,
    .reduced_chisq_o, .dof_error_o
  );

  always #5 clk_i = ~clk_i;

  logic [11:0] roi_start, roi_end;
  logic [5:0]  n_fitted;
  logic [11:0] chan_idx;
  logic [63:0] meas_total, meas_roi, calc_total, calc_roi, chisq_acc;

  chan_stats_t expected_stats_q[$];
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_spectra = 0;
  longint unsigned n_cycles = 0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] lim);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64] || s[63:0] > lim) return lim;
    return s[63:0];
  endfunction

  function automatic chan_stats_t predict_channel(logic [CountBits-1:0] meas,
                                                  logic [CalcBits-1:0] calc,
                                                  logic last_in);
    chan_stats_t r;
    logic [63:0] mq, mag, term, chans, tot, roi, red;
    logic last, in_roi;
    last = last_in || (chan_idx >= 12'd4095);
    mq = 64'(meas) << FracBits;
    if (mq >= 64'(calc)) begin
      mag = mq - 64'(calc);
      r.residual = mag[ResBits-1:0];
    end else begin
      mag = 64'(calc) - mq;
      r.residual = ResBits'(-mag);
    end
    term = ((mag * mag) / (64'(meas) + 64'd2)) >> FracBits;
    meas_total = sat_add(meas_total, 64'(meas), Sum36Max);
    calc_total = sat_add(calc_total, 64'(calc), Sum44Max);
    chisq_acc = sat_add(chisq_acc, term, 64'hFFFF_FFFF_FFFF_FFFF);
    in_roi = !last && chan_idx >= roi_start && chan_idx < roi_end;
    if (in_roi) begin
      meas_roi = sat_add(meas_roi, 64'(meas), Sum36Max);
      calc_roi = sat_add(calc_roi, 64'(calc), Sum44Max);
    end
    r.stats_valid = 1'b0;
    r.total_counts = '0;
    r.region_counts = '0;
    r.reduced_chisq = '0;
    r.dof_error = 1'b0;
    if (!last) begin
      chan_idx = chan_idx + 12'd1;
      return r;
    end
    chans = 64'(chan_idx) + 64'd1;
    tot = (meas_total == 0) ? (calc_total >> FracBits) : meas_total;
    roi = (meas_roi == 0) ? (calc_roi >> FracBits) : meas_roi;
    if (chans <= 64'(n_fitted)) begin
      r.dof_error = 1'b1;
      red = Chi48Max;
    end else begin
      red = chisq_acc / (chans - 64'(n_fitted));
      if (red > Chi48Max) red = Chi48Max;
    end
    r.stats_valid = 1'b1;
    r.total_counts = tot[TotBits-1:0];
    r.region_counts = roi[TotBits-1:0];
    r.reduced_chisq = red[RedBits-1:0];
    chan_idx = '0;
    meas_total = '0;
    meas_roi = '0;
    calc_total = '0;
    calc_roi = '0;
    chisq_acc = '0;
    return r;
  endfunction

  // The request stays on the bus through a zero gap, so the next one follows it directly.
  task automatic idle_gap();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = 0;
      5, 6, 7: n = $urandom_range(1, 3);
      8: n = $urandom_range(4, 12);
      default: n = $urandom_range(20, 80);
    endcase
    if (n != 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_channel(logic [CountBits-1:0] meas, logic [CalcBits-1:0] calc,
                              logic last, logic has_exp, chan_stats_t exp_row);
    chan_stats_t p;
    push <= 1'b1;
    measured_count_i <= meas;
    calculated_count_i <= calc;
    last_channel_i <= last;
    do @(posedge clk_i); while (full);
    p = predict_channel(meas, calc, last);
    if (has_exp && p !== exp_row) begin
      $display("%0t: table row disagrees with prediction exp=%h act=%h",
               $time, exp_row, p);
      n_errors++;
    end
    expected_stats_q.insert(expected_stats_q.size(), p);
    if (last) n_spectra++;
  endtask

  task automatic write_reg(cfg_addr_t idx, logic [CfgDataBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgRegionStart: roi_start = val;
      CfgRegionEnd: roi_end = val;
      default: n_fitted = val[5:0];
    endcase
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic [11:0] s, logic [11:0] e, logic [5:0] f);
    drain();
    write_reg(CfgRegionStart, s);
    write_reg(CfgRegionEnd, e);
    write_reg(CfgFittedComps, {6'd0, f});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CountBits-1:0] rand_meas();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CountBits'($urandom_range(0, 15));
      3: return CountBits'($urandom_range(0, 4000));
      default: return CountBits'($urandom);
    endcase
  endfunction

  function automatic logic [CalcBits-1:0] rand_calc(logic [CountBits-1:0] meas);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {meas, 8'h00} + CalcBits'($urandom_range(0, 4095)) - 32'd2048;
      default: return $urandom;
    endcase
  endfunction

  // Consumer: pops with random stalls and checks against the oldest expectation.
  always @(posedge clk_i) begin
    chan_stats_t act, exp_r;
    if (rst_ni && pop && !empty) begin
      act = '{residual_o, stats_valid_o, total_counts_o, region_counts_o,
              reduced_chisq_o, dof_error_o};
      if (expected_stats_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        n_errors++;
      end else begin
        exp_r = expected_stats_q.pop_front();
        n_results++;
        if (act.residual !== exp_r.residual)
          $display("%0t: residual exp=%h act=%h", $time, exp_r.residual, act.residual);
        if (act.stats_valid !== exp_r.stats_valid)
          $display("%0t: stats_valid exp=%b act=%b", $time, exp_r.stats_valid,
                   act.stats_valid);
        if (act.total_counts !== exp_r.total_counts)
          $display("%0t: total_counts exp=%h act=%h", $time, exp_r.total_counts,
                   act.total_counts);
        if (act.region_counts !== exp_r.region_counts)
          $display("%0t: region_counts exp=%h act=%h", $time, exp_r.region_counts,
                   act.region_counts);
        if (act.reduced_chisq !== exp_r.reduced_chisq)
          $display("%0t: reduced_chisq exp=%h act=%h", $time, exp_r.reduced_chisq,
                   act.reduced_chisq);
        if (act.dof_error !== exp_r.dof_error)
          $display("%0t: dof_error exp=%b act=%b", $time, exp_r.dof_error,
                   act.dof_error);
        if (act !== exp_r) n_errors++;
      end
    end
    if (rst_ni) pop <= ($urandom_range(0, 9) < 2) ? 1'b0 :
                       ($urandom_range(0, 30) == 0) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("spectrum_residual_chisq_stats_unit regression: fail");
      $finish;
    end
  end

  chan_row_t dir_rows[$];

  function automatic chan_stats_t stats_row(logic [ResBits-1:0] r);
    return '{r, 1'b0, '0, '0, '0, 1'b0};
  endfunction

  function automatic void add_row(logic [CountBits-1:0] meas, logic [CalcBits-1:0] calc,
                                  logic last, logic has_exp, chan_stats_t exp_row);
    chan_row_t row;
    row.meas = meas;
    row.calc = calc;
    row.last = last;
    row.has_expected = has_exp;
    row.expected = exp_row;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  initial begin
    int unsigned spec_len, sent;
    roi_start = 12'd0;
    roi_end = 12'd4095;
    n_fitted = 6'd0;
    chan_idx = '0;
    meas_total = '0;
    meas_roi = '0;
    calc_total = '0;
    calc_roi = '0;
    chisq_acc = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Expected values are given where they are obvious.
    add_row(24'd0, 32'd0, 1'b0, 1'b1, stats_row('0));
    add_row(24'd1, 32'd0, 1'b0, 1'b1, stats_row(33'd256));
    add_row(24'd0, 32'd256, 1'b0, 1'b1, stats_row(-33'sd256));
    add_row(24'hFFFFFF, 32'd0, 1'b0, 1'b1, stats_row(33'h0FFFFFF00));
    add_row(24'd0, 32'hFFFFFFFF, 1'b0, 1'b1, stats_row(33'h100000001));
    add_row(24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, stats_row('0));
    add_row(24'd10, 32'd2560, 1'b1, 1'b0, stats_row('0));
    // Single channel spectrum with no fitted components.
    add_row(24'd0, 32'd0, 1'b1, 1'b1, '{'0, 1'b1, '0, '0, '0, 1'b0});
    // Zero measured counts: totals fall back to the fitted sum.
    add_row(24'd0, 32'd1000, 1'b0, 1'b0, stats_row('0));
    add_row(24'd0, 32'd600, 1'b1, 1'b0, stats_row('0));
    foreach (dir_rows[i])
      send_channel(dir_rows[i].meas, dir_rows[i].calc, dir_rows[i].last,
                   dir_rows[i].has_expected, dir_rows[i].expected);

    // Bad degree count with maximum components, then narrow and inverted windows.
    configure(12'd0, 12'd0, 6'd63);
    send_channel(24'd5, 32'd9, 1'b0, 1'b0, '0);
    send_channel(24'd5, 32'd9, 1'b1, 1'b0, '0);
    configure(12'd1, 12'd3, 6'd1);
    for (int i = 0; i < 5; i++) send_channel(rand_meas(), $urandom, i == 4, 1'b0, '0);
    configure(12'd4095, 12'd0, 6'd2);
    for (int i = 0; i < 4; i++) send_channel(24'd3, $urandom, i == 3, 1'b0, '0);

    sent = 0;
    while (sent < NumRandom) begin
      if ($urandom_range(0, 3) == 0)
        configure(12'($urandom_range(0, 20)),
                  ($urandom_range(0, 4) == 0) ? 12'hFFF : 12'($urandom_range(0, 24)),
                  ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4)));
      spec_len = $urandom_range(1, 24);
      for (int i = 0; i < spec_len; i++) begin
        logic [CountBits-1:0] mv;
        mv = rand_meas();
        send_channel(mv, rand_calc(mv), i == spec_len - 1, 1'b0, '0);
        idle_gap();
        sent++;
      end
    end

    drain();
    $display("Checked %0d results over %0d spectra, including saturation, fallback,",
             n_results, n_spectra);
    $display("bad degree counts and varied region windows.");
    if (n_errors == 0) begin
      $display("spectrum_residual_chisq_stats_unit regression: pass");
    end else begin
      $display("spectrum_residual_chisq_stats_unit regression: fail");
    end
    $finish;
  end
endmodule

/* spectrum_residual_chisq_stats_unit.f */
rtl/srcs_pkg.sv
rtl/srcs_front.sv
rtl/srcs_back.sv
rtl/spectrum_residual_chisq_stats_unit.sv
tb/tb_spectrum_residual_chisq_stats_unit.sv
